// ===== rtl/lot_pkg.sv =====
// Shared types and constants for the LRU order tracker.
`timescale 1ns / 1ps

package lot_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int IDX_W       = 6;
    localparam int LINK_W      = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRY_COUNT);

    typedef enum logic [1:0] {
        OP_TOUCH  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EVICT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_NOT_LISTED = 2'd1,
        ERR_LISTED     = 2'd2,
        ERR_EMPTY      = 2'd3
    } err_t;

    typedef struct packed {
        logic [IDX_W-1:0]  victim_index;
        logic              victim_valid;
        logic [LINK_W-1:0] head_index;
        logic [LINK_W-1:0] tail_index;
        err_t              error_code;
    } result_t;

endpackage

// ===== rtl/lru_order_tracker_core.sv =====
// Top level of the LRU order tracker with its stream ports.
`timescale 1ns / 1ps

// The tracker keeps the recency order of 64 table slots as a doubly linked list and answers
// every input transfer with exactly one result transfer: the evicted slot, the new head and
// tail (64 when the list is empty) and an error code. A transfer is taken into an input
// register and its whole list update is done combinationally as it moves into the result
// register, so one transfer is accepted per cycle while the result side does not stall. The
// sustained rate is set by the update of the link registers. The list is empty right after
// reset, with no clearing pass. While a finished result waits for the downstream side, the
// input register accepts a transfer only if it is empty.
module lru_order_tracker_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: operation (2), entry_index (6).
    input  logic [lot_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: victim_index (6), victim_valid (1), head_index (7),
    // tail_index (7), error_code (2), one zero pad bit.
    output logic [lot_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                      in_valid_reg;
    lot_pkg::op_t              in_op_reg;
    logic [lot_pkg::IDX_W-1:0] in_idx_reg;
    logic                      out_valid_reg;
    lot_pkg::result_t          out_data_reg;
    lot_pkg::result_t          step_result;
    logic                      out_load;
    logic                      step_en;

    assign out_load = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || step_en;

    lot_list_state u_list_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .op      (in_op_reg),
        .idx     (in_idx_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= lot_pkg::op_t'(s_tdata[1:0]);
            in_idx_reg <= s_tdata[7:2];
        end
        if (step_en) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_data_reg.error_code,
                       out_data_reg.tail_index,
                       out_data_reg.head_index,
                       out_data_reg.victim_valid,
                       out_data_reg.victim_index};

endmodule

// ===== rtl/lot_list_state.sv =====
// Recency list state: link registers, membership bits, head and tail, and the update logic.
`timescale 1ns / 1ps

module lot_list_state (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  lot_pkg::op_t              op,
    input  logic [lot_pkg::IDX_W-1:0] idx,
    output lot_pkg::result_t          result
);

    logic [lot_pkg::LINK_W-1:0]      prev_reg [lot_pkg::ENTRY_COUNT];
    logic [lot_pkg::LINK_W-1:0]      next_reg [lot_pkg::ENTRY_COUNT];
    logic [lot_pkg::ENTRY_COUNT-1:0] in_list_reg;
    logic [lot_pkg::ENTRY_COUNT-1:0] in_list_next;
    logic [lot_pkg::LINK_W-1:0]      head_reg;
    logic [lot_pkg::LINK_W-1:0]      tail_reg;
    logic [lot_pkg::LINK_W-1:0]      head_next;
    logic [lot_pkg::LINK_W-1:0]      tail_next;

    logic [lot_pkg::IDX_W-1:0]  unlink_idx;
    logic [lot_pkg::LINK_W-1:0] prev_link;
    logic [lot_pkg::LINK_W-1:0] next_link;
    logic [lot_pkg::LINK_W-1:0] head_mid;
    logic [lot_pkg::LINK_W-1:0] tail_mid;
    logic [lot_pkg::LINK_W-1:0] idx_link;
    logic                       do_unlink;
    logic                       do_link;
    logic                       victim_valid;
    lot_pkg::err_t              err;
    logic                       next_a_en;
    logic                       prev_c_en;
    logic                       prev_e_en;

    assign idx_link   = {1'b0, idx};
    assign unlink_idx = (op == lot_pkg::OP_EVICT) ? tail_reg[lot_pkg::IDX_W-1:0] : idx;
    assign prev_link  = prev_reg[unlink_idx];
    assign next_link  = next_reg[unlink_idx];

    always_comb begin
        err          = lot_pkg::ERR_OK;
        do_unlink    = 1'b0;
        do_link      = 1'b0;
        victim_valid = 1'b0;
        case (op)
            lot_pkg::OP_TOUCH: begin
                if (!in_list_reg[idx]) begin
                    err = lot_pkg::ERR_NOT_LISTED;
                end else if (idx_link != head_reg) begin
                    do_unlink = 1'b1;
                    do_link   = 1'b1;
                end
            end
            lot_pkg::OP_INSERT: begin
                if (in_list_reg[idx]) begin
                    err = lot_pkg::ERR_LISTED;
                end else begin
                    do_link = 1'b1;
                end
            end
            lot_pkg::OP_REMOVE: begin
                if (!in_list_reg[idx]) begin
                    err = lot_pkg::ERR_NOT_LISTED;
                end else begin
                    do_unlink = 1'b1;
                end
            end
            lot_pkg::OP_EVICT: begin
                if (tail_reg == lot_pkg::LINK_NONE) begin
                    err = lot_pkg::ERR_EMPTY;
                end else begin
                    do_unlink    = 1'b1;
                    victim_valid = 1'b1;
                end
            end
            default: begin
                err = lot_pkg::ERR_OK;
            end
        endcase
    end

    // Unlinking first, then linking at the front against the head left by the unlink.
    always_comb begin
        head_mid  = (do_unlink && prev_link == lot_pkg::LINK_NONE) ? next_link : head_reg;
        tail_mid  = (do_unlink && next_link == lot_pkg::LINK_NONE) ? prev_link : tail_reg;
        head_next = do_link ? idx_link : head_mid;
        tail_next = (do_link && head_mid == lot_pkg::LINK_NONE) ? idx_link : tail_mid;
        next_a_en = do_unlink && (prev_link != lot_pkg::LINK_NONE);
        prev_c_en = do_unlink && (next_link != lot_pkg::LINK_NONE);
        prev_e_en = do_link && (head_mid != lot_pkg::LINK_NONE);
        in_list_next = in_list_reg;
        if (do_unlink) begin
            in_list_next[unlink_idx] = 1'b0;
        end
        if (do_link) begin
            in_list_next[idx] = 1'b1;
        end
    end

    always_comb begin
        result.victim_index = victim_valid ? tail_reg[lot_pkg::IDX_W-1:0] : '0;
        result.victim_valid = victim_valid;
        result.head_index   = head_next;
        result.tail_index   = tail_next;
        result.error_code   = err;
    end

    // Links of an entry are always written when it joins the list, so they need no reset.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int i = 0; i < lot_pkg::ENTRY_COUNT; i++) begin
                if (do_link && idx == lot_pkg::IDX_W'(i)) begin
                    next_reg[i] <= head_mid;
                end else if (next_a_en
                             && prev_link[lot_pkg::IDX_W-1:0] == lot_pkg::IDX_W'(i)) begin
                    next_reg[i] <= next_link;
                end
                if (prev_e_en && head_mid[lot_pkg::IDX_W-1:0] == lot_pkg::IDX_W'(i)) begin
                    prev_reg[i] <= idx_link;
                end else if (do_link && idx == lot_pkg::IDX_W'(i)) begin
                    prev_reg[i] <= lot_pkg::LINK_NONE;
                end else if (prev_c_en
                             && next_link[lot_pkg::IDX_W-1:0] == lot_pkg::IDX_W'(i)) begin
                    prev_reg[i] <= prev_link;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_list_reg <= '0;
            head_reg    <= lot_pkg::LINK_NONE;
            tail_reg    <= lot_pkg::LINK_NONE;
        end else if (step_en) begin
            in_list_reg <= in_list_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == lot_pkg::LINK_NONE) == (tail_reg == lot_pkg::LINK_NONE))
        else $error("Head and tail disagree on whether the list is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == lot_pkg::LINK_NONE) |-> (in_list_reg == '0))
        else $error("Entries are marked listed while the list is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != lot_pkg::LINK_NONE) |->
            (in_list_reg[head_reg[lot_pkg::IDX_W-1:0]]
             && prev_reg[head_reg[lot_pkg::IDX_W-1:0]] == lot_pkg::LINK_NONE))
        else $error("Head entry is not listed or has a predecessor.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg != lot_pkg::LINK_NONE) |->
            (in_list_reg[tail_reg[lot_pkg::IDX_W-1:0]]
             && next_reg[tail_reg[lot_pkg::IDX_W-1:0]] == lot_pkg::LINK_NONE))
        else $error("Tail entry is not listed or has a successor.");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LRU order tracker stream core.
`timescale 1ns / 1ps

module tb_top;
    import lot_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [IDX_W-1:0]  victim;
        logic              victim_valid;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        err_t              err;
    } outcome_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [LINK_W-1:0] prv [ENTRY_COUNT] = '{default: LINK_NONE};
    logic [LINK_W-1:0] nxt [ENTRY_COUNT] = '{default: LINK_NONE};
    logic              member [ENTRY_COUNT] = '{default: 1'b0};
    logic [LINK_W-1:0] lru_head = LINK_NONE;
    logic [LINK_W-1:0] lru_tail = LINK_NONE;
    int                listed_count = 0;

    outcome_t outcome_q[$];
    int       mismatches  = 0;
    int       stall_cycles = 0;
    int       ready_left  = 0;
    bit       idling      = 1'b0;

    lru_order_tracker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void detach(input logic [IDX_W-1:0] s);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = prv[s];
        n = nxt[s];
        if (p < ENTRY_COUNT) nxt[p[IDX_W-1:0]] = n;
        else lru_head = n;
        if (n < ENTRY_COUNT) prv[n[IDX_W-1:0]] = p;
        else lru_tail = p;
        prv[s] = LINK_NONE;
        nxt[s] = LINK_NONE;
        member[s] = 1'b0;
        listed_count--;
    endfunction

    function automatic void attach_front(input logic [IDX_W-1:0] s);
        prv[s] = LINK_NONE;
        nxt[s] = lru_head;
        if (lru_head < ENTRY_COUNT) prv[lru_head[IDX_W-1:0]] = {1'b0, s};
        else lru_tail = {1'b0, s};
        lru_head = {1'b0, s};
        member[s] = 1'b1;
        listed_count++;
    endfunction

    function automatic outcome_t lru_update(input op_t op, input logic [IDX_W-1:0] idx);
        outcome_t res;
        res = '0;
        res.err = ERR_OK;
        case (op)
            OP_TOUCH: begin
                if (!member[idx]) res.err = ERR_NOT_LISTED;
                else if ({1'b0, idx} != lru_head) begin
                    detach(idx);
                    attach_front(idx);
                end
            end
            OP_INSERT: begin
                if (member[idx]) res.err = ERR_LISTED;
                else attach_front(idx);
            end
            OP_REMOVE: begin
                if (!member[idx]) res.err = ERR_NOT_LISTED;
                else detach(idx);
            end
            default: begin
                if (lru_tail >= ENTRY_COUNT) begin
                    res.err = ERR_EMPTY;
                end else begin
                    res.victim       = lru_tail[IDX_W-1:0];
                    res.victim_valid = 1'b1;
                    detach(lru_tail[IDX_W-1:0]);
                end
            end
        endcase
        res.head = lru_head;
        res.tail = lru_tail;
        return res;
    endfunction

    function automatic logic [LINK_W-1:0] pick_slot(input logic listed);
        logic [IDX_W-1:0] pool[$];
        for (int i = 0; i < ENTRY_COUNT; i++)
            if (member[i] == listed) pool.push_back(IDX_W'(i));
        if (pool.size() == 0) return LINK_NONE;
        return {1'b0, pool[$urandom_range(0, pool.size() - 1)]};
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic issue_op(input op_t op, input logic [IDX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, op};
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(lru_update(op, idx));
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outcome_q.size() != 0);
    endtask

    task automatic churn(input int n_items, input int fill_target);
        op_t               op;
        logic [LINK_W-1:0] pick;
        int                grow;
        for (int i = 0; i < n_items; i++) begin
            grow = (listed_count < fill_target) ? 75 : 25;
            pick = LINK_NONE;
            if ($urandom_range(0, 99) < 8) begin
                op = op_t'($urandom_range(0, 3));
            end else if ($urandom_range(0, 99) < 30) begin
                op = OP_TOUCH;
                case ($urandom_range(0, 3))
                    0: pick = lru_head;
                    1: pick = lru_tail;
                    default: pick = pick_slot(1'b1);
                endcase
            end else if ($urandom_range(0, 99) < grow) begin
                op   = OP_INSERT;
                pick = pick_slot(1'b0);
            end else if ($urandom_range(0, 1) == 1) begin
                op = OP_EVICT;
            end else begin
                op = OP_REMOVE;
                case ($urandom_range(0, 3))
                    0: pick = lru_head;
                    1: pick = lru_tail;
                    default: pick = pick_slot(1'b1);
                endcase
            end
            if (pick < ENTRY_COUNT) issue_op(op, pick[IDX_W-1:0]);
            else issue_op(op, IDX_W'($urandom_range(0, ENTRY_COUNT - 1)));
        end
    endtask

    task automatic test_empty_list();
        idling = 1'b0;
        issue_op(OP_EVICT, 6'd0);
        issue_op(OP_TOUCH, 6'd0);
        issue_op(OP_REMOVE, 6'd63);
        issue_op(OP_EVICT, 6'd63);
    endtask

    task automatic test_build_and_touch();
        issue_op(OP_INSERT, 6'd0);
        issue_op(OP_INSERT, 6'd63);
        issue_op(OP_INSERT, 6'd42);
        issue_op(OP_INSERT, 6'd21);
        issue_op(OP_INSERT, 6'd63);
        issue_op(OP_TOUCH, 6'd21);
        issue_op(OP_TOUCH, 6'd0);
        issue_op(OP_TOUCH, 6'd63);
        issue_op(OP_TOUCH, 6'd5);
    endtask

    task automatic test_unlink_and_evict();
        issue_op(OP_REMOVE, 6'd0);
        issue_op(OP_REMOVE, 6'd63);
        issue_op(OP_REMOVE, 6'd42);
        issue_op(OP_REMOVE, 6'd42);
        issue_op(OP_EVICT, 6'd17);
        issue_op(OP_EVICT, 6'd0);
    endtask

    task automatic test_random_churn();
        idling = 1'b1;
        hold_until_drained();
        churn(250, 4);
        hold_until_drained();
        churn(300, 32);
        churn(350, ENTRY_COUNT);
        hold_until_drained();
        churn(250, 10);
        churn(200, 0);
    endtask

    task automatic test_back_to_back();
        idling = 1'b0;
        churn(200, 20);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t ns: unexpected result transfer, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                compare_field("victim_index", want.victim, m_tdata[5:0]);
                compare_field("victim_valid", want.victim_valid, m_tdata[6]);
                compare_field("head_index", want.head, m_tdata[13:7]);
                compare_field("tail_index", want.tail, m_tdata[20:14]);
                compare_field("error_code", want.err, m_tdata[22:21]);
                compare_field("pad bit", 0, m_tdata[23]);
            end
        end
    end

    always @(posedge aclk) begin : ready_gen
        int r;
        if (!idling) begin
            m_tready <= 1'b1;
            ready_left = 0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
                ready_left = $urandom_range(1, 8);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end else begin
                m_tready <= 1'b0;
                ready_left = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("lru_order_tracker_core verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_build_and_touch();
        test_unlink_and_evict();
        test_random_churn();
        test_back_to_back();
        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("lru_order_tracker_core verification clean");
        end else begin
            $display("lru_order_tracker_core verification failed");
        end
        $finish;
    end

endmodule
